// ===== design/six_step_fft_frame_core_assert.svh =====
// six_step_fft_frame_core_assert.svh - assertion macros for the fft frame core
// depends on nothing; included by modules that check their own sequencing
`ifndef SIX_STEP_FFT_FRAME_CORE_ASSERT_SVH
`define SIX_STEP_FFT_FRAME_CORE_ASSERT_SVH
// implication checked on every clock outside reset
`define SSF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/ssf_pkg.sv =====
// ssf_pkg.sv - shared types, constants and twiddle table of the fft frame core
// depends on nothing
package ssf_pkg;
  localparam int ROWS = 8;
  localparam int COLS = 8;
  localparam int NPTS = ROWS * COLS;
  localparam int DW = 23;
  localparam int WW = 16;

  typedef logic signed [DW-1:0] data_t;
  typedef logic [5:0] expo_t;

  // round-half-up 32768*cos(2*pi*k/64), k = 0..16
  function automatic logic [16:0] qcos(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0: v = 17'd32768; 5'd1: v = 17'd32610; 5'd2: v = 17'd32138;
      5'd3: v = 17'd31357; 5'd4: v = 17'd30274; 5'd5: v = 17'd28899;
      5'd6: v = 17'd27246; 5'd7: v = 17'd25330; 5'd8: v = 17'd23170;
      5'd9: v = 17'd20788; 5'd10: v = 17'd18205; 5'd11: v = 17'd15447;
      5'd12: v = 17'd12540; 5'd13: v = 17'd9512; 5'd14: v = 17'd6393;
      5'd15: v = 17'd3212; default: v = 17'd0;
    endcase
    return v;
  endfunction

  // cosine of 2*pi*e/64 in Q1.15, +1 saturated to 32767
  function automatic logic signed [WW-1:0] cos64(input expo_t e);
    logic signed [17:0] s;
    case (e[5:4])
      2'd0: s = $signed({1'b0, qcos({1'b0, e[3:0]})});
      2'd1: s = -$signed({1'b0, qcos(5'd16 - {1'b0, e[3:0]})});
      2'd2: s = -$signed({1'b0, qcos({1'b0, e[3:0]})});
      default: s = $signed({1'b0, qcos(5'd16 - {1'b0, e[3:0]})});
    endcase
    if (s > 18'sd32767) s = 18'sd32767;
    return s[WW-1:0];
  endfunction
endpackage

// ===== design/ssf_cmul.sv =====
// ssf_cmul.sv - shared complex twiddle multiplier, two registered stages
// depends on ssf_pkg
module ssf_cmul (
  input  logic                 clk,
  input  ssf_pkg::data_t       a_re,
  input  ssf_pkg::data_t       a_im,
  input  ssf_pkg::expo_t       e,
  output ssf_pkg::data_t       p_re,
  output ssf_pkg::data_t       p_im
);
  logic signed [15:0] wr, wi;
  logic signed [40:0] prr, pii, pri, pir;
  logic bypass;
  ssf_pkg::data_t byp_re, byp_im;
  logic signed [41:0] sre, sim;

  assign wr = ssf_pkg::cos64(e);
  assign wi = ssf_pkg::cos64(e + 6'd16);

  // stage one: four partial products
  always_ff @(posedge clk) begin
    prr <= 41'(a_re) * 41'(wr);
    pii <= 41'(a_im) * 41'(wi);
    pri <= 41'(a_re) * 41'(wi);
    pir <= 41'(a_im) * 41'(wr);
    bypass <= (e == 6'd0);
    byp_re <= a_re;
    byp_im <= a_im;
  end

  // stage two: sum and round half up
  assign sre = 42'(prr) - 42'(pii) + 42'sd16384;
  assign sim = 42'(pri) + 42'(pir) + 42'sd16384;
  always_ff @(posedge clk) begin
    p_re <= bypass ? byp_re : sre[37:15];
    p_im <= bypass ? byp_im : sim[37:15];
  end
endmodule

// ===== design/six_step_fft_frame_core.sv =====
// A frame of 64 samples is taken in row-major order, one transfer per start while busy is
// low; the 64th transfer raises busy. The block then runs eight row DFTs, the twiddle pass
// and eight column DFTs on one shared pipelined complex multiplier: a butterfly makes two
// reads, passes two multiply stages and makes two writes back, and a twiddle reads,
// multiplies and writes back in place, for 192 butterflies and 64 twiddles. After a first
// read the 64 results follow in column-major order, one per cycle on result_valid, last
// marked; busy stays high until the last result. Results cannot be stalled. Frame memory
// is a 64-entry array, one read and one write port.
// depends on ssf_pkg, ssf_cmul, six_step_fft_frame_core_assert.svh
`include "six_step_fft_frame_core_assert.svh"
module six_step_fft_frame_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   sample_re,
  input  logic signed [15:0]   sample_im,
  output logic                 result_valid,
  output logic signed [22:0]   result_re,
  output logic signed [22:0]   result_im,
  output logic                 last_result
);
  typedef enum logic [2:0] {S_LOAD, S_BFLY, S_TWID, S_OUT} state_t;
  state_t state;
  logic [6:0] load_count;
  logic [1:0] phase;       // 0 read u, 1 read t, 2 wait, 3 write
  logic [1:0] pass;        // 0 rows, 1 columns
  logic [2:0] line;        // row or column index
  logic [1:0] stg;         // butterfly stage
  logic [1:0] bfi;         // butterfly within stage
  logic [5:0] tw_idx;
  logic [6:0] out_idx;
  logic [2:0] sub;

  logic [45:0] mem [ssf_pkg::NPTS];
  logic [5:0] raddr, waddr;
  logic [45:0] rdata, wdata;
  logic wen;
  ssf_pkg::data_t u_re, u_im, m_re, m_im;
  ssf_pkg::expo_t e;
  ssf_pkg::data_t ain_re, ain_im;
  logic [2:0] ku, kt;
  logic [1:0] j;
  logic [2:0] i_u, i_t;

  // butterfly position: stage s, butterfly b -> element indices in natural DIT order
  // memory holds lines in bit-reversed order after load via reversed write address
  always_comb begin
    j = 2'(bfi & ((2'd1 << stg) - 2'd1));
    case (stg)
      2'd0: i_u = {bfi, 1'b0};
      2'd1: i_u = {bfi[1], 1'b0, bfi[0]};
      default: i_u = {1'b0, bfi};
    endcase
    i_t = 3'(i_u + (3'd1 << stg));
    e = 6'(j) * (6'd32 >> stg);
    ku = i_u; kt = i_t;
  end

  function automatic logic [2:0] rev3(input logic [2:0] x);
    return {x[0], x[1], x[2]};
  endfunction

  // address of element k of the current line, columns kept in bit-reversed row order
  function automatic logic [5:0] adr(input logic [1:0] p, input logic [2:0] l,
                                     input logic [2:0] k);
    return (p == 2'd0) ? {l, k} : {rev3(k), l};
  endfunction

  // memory with registered read
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  ssf_cmul u_cmul (.clk(clk), .a_re(ain_re), .a_im(ain_im), .e(state == S_TWID ?
    6'(tw_idx[5:3]) * 6'(tw_idx[2:0]) : e), .p_re(m_re), .p_im(m_im));

  always_comb begin
    raddr = '0; wen = 1'b0; waddr = '0; wdata = '0;
    ain_re = rdata[45:23]; ain_im = rdata[22:0];
    case (state)
      S_LOAD: begin
        wen = start;
        waddr = {load_count[5:3], rev3(load_count[2:0])};
        wdata = {23'(sample_re), 23'(sample_im)};
      end
      S_BFLY: begin
        // wait for the product, then write back sum and difference
        raddr = adr(pass, line, phase == 2'd0 ? ku : kt);
        waddr = adr(pass, line, (sub == 3'd2) ? kt : ku);
        wen = (phase == 2'd3) && (sub != 3'd0);
        wdata = (sub == 3'd2) ? {23'(u_re - m_re), 23'(u_im - m_im)}
                              : {23'(u_re + m_re), 23'(u_im + m_im)};
      end
      S_TWID: begin
        // row r col c after the row pass, rotated in place
        raddr = tw_idx;
        waddr = tw_idx;
        wen = (phase == 2'd3);
        wdata = {m_re, m_im};
      end
      S_OUT: raddr = {rev3(out_idx[2:0]), out_idx[5:3]};
      default: ;
    endcase
  end

  assign busy = (state != S_LOAD);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; load_count <= '0; result_valid <= 1'b0; last_result <= 1'b0;
      phase <= '0; pass <= '0; line <= '0; stg <= '0; bfi <= '0; tw_idx <= '0;
      out_idx <= '0; sub <= '0;
    end else begin
      result_valid <= 1'b0; last_result <= 1'b0;
      case (state)
        S_LOAD: if (start) begin
          if (load_count == 7'(ssf_pkg::NPTS - 1)) begin
            load_count <= '0; state <= S_BFLY; pass <= '0; line <= '0;
            stg <= '0; bfi <= '0; phase <= '0; sub <= '0;
          end else load_count <= load_count + 7'd1;
        end
        S_BFLY: begin
          if (phase == 2'd1) begin u_re <= rdata[45:23]; u_im <= rdata[22:0]; end
          if (phase == 2'd3 && sub != 3'd2) sub <= sub + 3'd1;
          else begin
            phase <= phase + 2'd1;
            if (phase == 2'd3) begin
              sub <= '0;
              if (bfi != 2'd3) bfi <= bfi + 2'd1;
              else begin
                bfi <= '0;
                if (stg != 2'd2) stg <= stg + 2'd1;
                else begin
                  stg <= '0;
                  if (line != 3'd7) line <= line + 3'd1;
                  else begin
                    line <= '0;
                    if (pass == 2'd0) begin state <= S_TWID; tw_idx <= '0; end
                    else begin state <= S_OUT; out_idx <= '0; end
                  end
                end
              end
            end
          end
        end
        S_TWID: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            if (tw_idx != 6'd63) tw_idx <= tw_idx + 6'd1;
            else begin state <= S_BFLY; pass <= 2'd1; end
          end
        end
        S_OUT: begin
          if (out_idx != 7'd0) begin
            result_valid <= 1'b1;
            result_re <= rdata[45:23]; result_im <= rdata[22:0];
            last_result <= (out_idx == 7'd64);
          end
          if (out_idx == 7'd64) state <= S_LOAD;
          else out_idx <= out_idx + 7'd1;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // sequencing checks
  `SSF_ASSERT_IMP(a_last_valid, last_result, result_valid)
  `SSF_ASSERT_IMP(a_load_range, state == S_LOAD, load_count < 7'd64)
  `SSF_ASSERT_NEXT(a_frame_go, state == S_LOAD && start && load_count == 7'd63, state == S_BFLY)
  `SSF_ASSERT_IMP(a_out_no_write, state == S_OUT, !wen)
endmodule

// ===== bench/tb.sv =====
// tb.sv - self-checking bench for the six-step fft frame core
// depends on six_step_fft_frame_core and its design files
`timescale 1ns / 1ps

module tb;
  localparam int NSAMP = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [22:0] re;
    logic signed [22:0] im;
    logic last;
  } fft_out_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  logic result_valid;
  logic signed [22:0] result_re;
  logic signed [22:0] result_im;
  logic last_result;

  six_step_fft_frame_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_re(sample_re), .sample_im(sample_im),
    .result_valid(result_valid), .result_re(result_re),
    .result_im(result_im), .last_result(last_result)
  );

  fft_out_t bins_due[$];
  longint frame_re[NSAMP];
  longint frame_im[NSAMP];
  int fill_count;
  int mismatches;
  int idle_cycles;
  int frames_done;
  int results_seen;
  bit no_gaps;

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // quarter-wave cosine table, Q1.15 round-half-up
  function automatic longint cos_q15(int e);
    longint qtab[17];
    int q;
    int r;
    longint v;
    qtab = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
             23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
    q = (e & 63) >> 4;
    r = e & 15;
    case (q)
      0: v = qtab[r];
      1: v = -qtab[16 - r];
      2: v = -qtab[r];
      default: v = qtab[16 - r];
    endcase
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // multiply by exp(-2*pi*i*e/64), each part rounded half-up
  function automatic void rotate(inout longint re, inout longint im, input int e);
    longint wr;
    longint wi;
    longint pr;
    longint pi;
    e = e & 63;
    if (e == 0) return;
    wr = cos_q15(e);
    wi = cos_q15(e + 16);
    pr = re * wr - im * wi;
    pi = re * wi + im * wr;
    re = (pr + 16384) >>> 15;
    im = (pi + 16384) >>> 15;
  endfunction

  // length-8 radix-2 dit transform in place
  function automatic void dft8(inout longint vr[8], inout longint vi[8]);
    longint tr[8];
    longint ti[8];
    longint ur;
    longint ui;
    longint xr;
    longint xi;
    int rev;
    for (int i = 0; i < 8; i++) begin
      rev = {i[0], i[1], i[2]};
      tr[i] = vr[rev];
      ti[i] = vi[rev];
    end
    for (int s = 2; s <= 8; s = s * 2) begin
      for (int i = 0; i < 8; i += s) begin
        for (int k = 0; k < s / 2; k++) begin
          ur = tr[i + k];
          ui = ti[i + k];
          xr = tr[i + k + s / 2];
          xi = ti[i + k + s / 2];
          rotate(xr, xi, k * (64 / s));
          tr[i + k] = ur + xr;
          ti[i + k] = ui + xi;
          tr[i + k + s / 2] = ur - xr;
          ti[i + k + s / 2] = ui - xi;
        end
      end
    end
    vr = tr;
    vi = ti;
  endfunction

  // row dfts, twiddle pass, column dfts, queue in column-major order
  task automatic predict_frame();
    longint wr[NSAMP];
    longint wi[NSAMP];
    longint lr[8];
    longint li[8];
    fft_out_t o;
    wr = frame_re;
    wi = frame_im;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        lr[c] = wr[r * 8 + c];
        li[c] = wi[r * 8 + c];
      end
      dft8(lr, li);
      for (int c = 0; c < 8; c++) begin
        rotate(lr[c], li[c], r * c);
        wr[r * 8 + c] = lr[c];
        wi[r * 8 + c] = li[c];
      end
    end
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) begin
        lr[r] = wr[r * 8 + c];
        li[r] = wi[r * 8 + c];
      end
      dft8(lr, li);
      for (int r = 0; r < 8; r++) begin
        o.re = lr[r][22:0];
        o.im = li[r][22:0];
        o.last = (c == 7 && r == 7);
        bins_due.push_back(o);
      end
    end
  endtask

  // sample transfers feed the predictor, results are checked in order
  always @(posedge clk) begin
    fft_out_t e;
    if (!rst) begin
      if (start && !busy) begin
        frame_re[fill_count] = sample_re;
        frame_im[fill_count] = sample_im;
        fill_count++;
        if (fill_count == NSAMP) begin
          fill_count = 0;
          frames_done++;
          predict_frame();
        end
      end
      if (result_valid) begin
        results_seen++;
        if (bins_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result re=%0d im=%0d", result_re, result_im);
        end else begin
          e = bins_due.pop_front();
          if (e.re !== result_re || e.im !== result_im || e.last !== last_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                       e.re, e.im, e.last, result_re, result_im, last_result);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  // send one sample, with a random idle cycle ahead of it
  task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
    if (!no_gaps && $urandom_range(99) < 14) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    sample_re <= re;
    sample_im <= im;
    do @(posedge clk); while (!(start && !busy));
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (bins_due.size() != 0) @(posedge clk);
  endtask

  // extremes, an impulse and alternating full-scale values
  task automatic test_extremes();
    logic [15:0] a;
    logic [15:0] b;
    for (int i = 0; i < NSAMP; i++) begin
      case (i % 4)
        0: begin a = 16'h7fff; b = 16'h8000; end
        1: begin a = 16'h8000; b = 16'h8000; end
        2: begin a = 16'h7fff; b = 16'h7fff; end
        default: begin a = (i == 3) ? 16'h0001 : 16'h0000; b = 16'hffff; end
      endcase
      send_sample(a, b);
    end
    drain();
  endtask

  // random partial frame, long hold-off, then finish the frame with no idling
  task automatic test_split_frame();
    for (int i = 0; i < 20; i++) send_sample(16'($urandom), 16'($urandom));
    start <= 0;
    repeat (200) @(posedge clk);
    no_gaps = 1;
    for (int i = 20; i < NSAMP; i++) send_sample(16'($urandom), 16'($urandom));
    no_gaps = 0;
    drain();
  endtask

  initial begin
    rst = 1;
    start = 0;
    sample_re = 0;
    sample_im = 0;
    fill_count = 0;
    mismatches = 0;
    frames_done = 0;
    results_seen = 0;
    no_gaps = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_split_frame();
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d frames, %0d results: full-scale corners and random samples,",
             frames_done, results_seen);
    $display("a frame split by a long pause and a gap-free run of transfers");
    if (mismatches == 0 && bins_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, bins_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
